FILE: hw/rtl/assert_macros.svh
// Assertion macros used by pats_dp.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must bring a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pats_pkg.sv
package pats_pkg;

	localparam int NUM_TASKS = 16;
	localparam int SLOT_W = $clog2(NUM_TASKS);
	localparam int CNT_W = $clog2(NUM_TASKS + 1);

	localparam int APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-1:0] REG_AGING_STEP = 3'd0;
	localparam logic [3:0] AGING_STEP_RESET = 4'd1;

	localparam logic signed [7:0] DYN_MIN = -8'sd128;

	typedef enum logic [1:0] {
		FUNC_ADD,
		FUNC_REMOVE,
		FUNC_SET_PRIO,
		FUNC_PICK
	} func_t;

	typedef enum logic [1:0] {
		ERR_OK,
		ERR_OCCUPIED,
		ERR_NOT_PRESENT
	} err_t;

	typedef struct packed {
		logic load_in;
		logic exec_op;
		logic scan_start;
		logic scan_step;
		logic apply_pick;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_pick;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

FILE: hw/rtl/pats_ctrl.sv
module pats_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  pats_pkg::dp_status_t status,
	output pats_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_APPLY,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   s_tready_q;

	assign s_tready = s_tready_q;

	always_comb begin
		cmd            = '0;
		cmd.load_in    = s_tvalid && s_tready_q;
		cmd.exec_op    = (state_q == ST_EXEC) && !status.is_pick;
		cmd.scan_start = (state_q == ST_EXEC) && status.is_pick;
		cmd.scan_step  = (state_q == ST_SCAN);
		cmd.apply_pick = (state_q == ST_APPLY);
		cmd.load_out   = (state_q == ST_DONE) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			s_tready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q    <= ST_EXEC;
						s_tready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					state_q <= status.is_pick ? ST_SCAN : ST_DONE;
				end
				ST_SCAN: begin
					if (status.scan_last) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (status.out_free) begin
						state_q    <= ST_IDLE;
						s_tready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					s_tready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/pats_dp.sv
`include "assert_macros.svh"

module pats_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pats_pkg::ctrl_cmd_t  cmd,
	output pats_pkg::dp_status_t status,
	input  logic [1:0]           func,
	input  logic [3:0]           task_slot,
	input  logic signed [5:0]    priority_req,
	input  logic [3:0]           aging_step,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [3:0]           picked_slot,
	output logic                 picked_valid,
	output logic signed [5:0]    slot_priority,
	output logic [1:0]           error_code
);

	localparam int N = pats_pkg::NUM_TASKS;
	localparam int SW = pats_pkg::SLOT_W;
	localparam int CW = pats_pkg::CNT_W;
	localparam logic signed [8:0] DYN_MIN_EXT = {pats_pkg::DYN_MIN[7], pats_pkg::DYN_MIN};

	// Latched request.
	pats_pkg::func_t    func_q;
	logic [3:0]         slot_q;
	logic signed [5:0]  req_q;

	// Task table.
	logic [N-1:0]       ready_q;
	logic signed [5:0]  stat_q [N];
	logic signed [7:0]  dyn_q  [N];
	logic [SW-1:0]      pos_q  [N];
	logic [CW-1:0]      cnt_q;

	// Scan state.
	logic [SW-1:0]      idx_q;
	logic               found_q;
	logic [SW-1:0]      best_q;
	logic signed [7:0]  best_dyn_q;
	logic [SW-1:0]      best_pos_q;

	// Result of the current item.
	logic [3:0]         res_slot_q;
	logic               res_valid_q;
	logic signed [5:0]  res_prio_q;
	pats_pkg::err_t     res_err_q;

	// Output register.
	logic               m_tvalid_q;
	logic [3:0]         out_slot_q;
	logic               out_valid_q;
	logic signed [5:0]  out_prio_q;
	logic [1:0]         out_err_q;

	logic [SW-1:0]      slot_idx;
	logic               in_range;
	logic [SW-1:0]      rd_idx;
	logic               rd_ready;
	logic signed [5:0]  rd_stat;
	logic signed [7:0]  rd_dyn;
	logic [SW-1:0]      rd_pos;
	logic               better;
	logic signed [7:0]  aged [N];
	logic signed [8:0]  diff [N];

	assign slot_idx = SW'(slot_q);
	assign in_range = 32'(slot_q) < N;

	always_comb begin
		if (cmd.scan_step) begin
			rd_idx = idx_q;
		end else if (cmd.apply_pick) begin
			rd_idx = best_q;
		end else begin
			rd_idx = slot_idx;
		end
	end

	assign rd_ready = ready_q[rd_idx];
	assign rd_stat  = stat_q[rd_idx];
	assign rd_dyn   = dyn_q[rd_idx];
	assign rd_pos   = pos_q[rd_idx];

	assign better = rd_ready && (!found_q || (rd_dyn < best_dyn_q) ||
		((rd_dyn == best_dyn_q) && (rd_pos < best_pos_q)));

	always_comb begin
		for (int i = 0; i < N; i++) begin
			diff[i] = {dyn_q[i][7], dyn_q[i]} - $signed({5'b0, aging_step});
			aged[i] = (diff[i] < 9'(DYN_MIN_EXT)) ? pats_pkg::DYN_MIN : diff[i][7:0];
		end
	end

	assign status.is_pick   = (func_q == pats_pkg::FUNC_PICK);
	assign status.scan_last = (idx_q == SW'(N - 1));
	assign status.out_free  = !m_tvalid_q || m_tready;

	// Control state of the table, scan and output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q    <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.exec_op && in_range) begin
				if (func_q == pats_pkg::FUNC_ADD && !rd_ready) begin
					ready_q[slot_idx] <= 1'b1;
					cnt_q             <= cnt_q + CW'(1);
				end else if (func_q == pats_pkg::FUNC_REMOVE && rd_ready) begin
					ready_q[slot_idx] <= 1'b0;
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
			end
			if (cmd.scan_start) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + SW'(1);
				if (better) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Table payload.
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (cmd.exec_op && in_range) begin
				if (func_q == pats_pkg::FUNC_ADD && !rd_ready && slot_idx == SW'(i)) begin
					stat_q[i] <= '0;
					dyn_q[i]  <= '0;
					pos_q[i]  <= SW'(cnt_q);
				end
				if (func_q == pats_pkg::FUNC_REMOVE && rd_ready && ready_q[i] &&
					slot_idx != SW'(i) && pos_q[i] > rd_pos) begin
					pos_q[i] <= pos_q[i] - SW'(1);
				end
				if (func_q == pats_pkg::FUNC_SET_PRIO && rd_ready && slot_idx == SW'(i)) begin
					stat_q[i] <= req_q;
					dyn_q[i]  <= {{2{req_q[5]}}, req_q};
				end
			end
			if (cmd.apply_pick && found_q) begin
				if (best_q == SW'(i)) begin
					dyn_q[i] <= {{2{stat_q[i][5]}}, stat_q[i]};
				end else if (ready_q[i]) begin
					dyn_q[i] <= aged[i];
				end
			end
		end
	end

	// Request, scan best and result payload.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= pats_pkg::func_t'(func);
			slot_q <= task_slot;
			req_q  <= priority_req;
		end
		if (cmd.scan_step && better) begin
			best_q     <= idx_q;
			best_dyn_q <= rd_dyn;
			best_pos_q <= rd_pos;
		end
		if (cmd.exec_op) begin
			res_slot_q  <= '0;
			res_valid_q <= 1'b0;
			if (!in_range) begin
				res_prio_q <= '0;
				res_err_q  <= pats_pkg::ERR_NOT_PRESENT;
			end else if (func_q == pats_pkg::FUNC_ADD) begin
				res_prio_q <= rd_ready ? rd_stat : 6'sd0;
				res_err_q  <= rd_ready ? pats_pkg::ERR_OCCUPIED : pats_pkg::ERR_OK;
			end else if (!rd_ready) begin
				res_prio_q <= '0;
				res_err_q  <= pats_pkg::ERR_NOT_PRESENT;
			end else if (func_q == pats_pkg::FUNC_REMOVE) begin
				res_prio_q <= rd_stat;
				res_err_q  <= pats_pkg::ERR_OK;
			end else begin
				res_prio_q <= req_q;
				res_err_q  <= pats_pkg::ERR_OK;
			end
		end
		if (cmd.apply_pick) begin
			res_err_q   <= pats_pkg::ERR_OK;
			res_slot_q  <= found_q ? 4'(best_q) : 4'd0;
			res_valid_q <= found_q;
			res_prio_q  <= found_q ? rd_stat : 6'sd0;
		end
		if (cmd.load_out) begin
			out_slot_q  <= res_slot_q;
			out_valid_q <= res_valid_q;
			out_prio_q  <= res_prio_q;
			out_err_q   <= res_err_q;
		end
	end

	assign m_tvalid      = m_tvalid_q;
	assign picked_slot   = out_slot_q;
	assign picked_valid  = out_valid_q;
	assign slot_priority = out_prio_q;
	assign error_code    = out_err_q;

	`ASSERT_ALWAYS(a_count_matches, clk, arst_n, $countones(ready_q) == int'(cnt_q), "ready count out of step with ready flags")
	`ASSERT_IMPLIES(a_best_is_ready, clk, arst_n, cmd.apply_pick && found_q, ready_q[best_q], "picked slot is not ready")
	`ASSERT_IMPLIES(a_pick_no_error, clk, arst_n, m_tvalid_q && out_valid_q, out_err_q == pats_pkg::ERR_OK, "pick word carries an error")

endmodule

FILE: hw/rtl/priority_aging_task_scheduler.sv
// Non-pick commands (add, remove, set priority) go from IDLE through EXEC to DONE after an accepted
// word; DONE registers their result word once the output is free, and the next word is taken in IDLE.
// A pick scans the table one slot per cycle in SCAN, then ages the other ready slots in APPLY before
// DONE; in both cases no new word is accepted until the result word has been loaded.
// The asynchronous reset empties the task table and sets the aging step to 1; the table
// needs no clearing pass and a word can be accepted in the first cycle after reset.
module priority_aging_task_scheduler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [15:0]                           s_tdata,  // task_slot, priority_req, pad
	input  logic [1:0]                            s_tuser,  // func
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// picked_slot, picked_valid, slot_priority, error_code, pad
	output logic [15:0]                           m_tdata,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [pats_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	pats_pkg::ctrl_cmd_t  cmd;
	pats_pkg::dp_status_t status;

	logic [3:0]        aging_step_q;
	logic [3:0]        picked_slot;
	logic              picked_valid;
	logic signed [5:0] slot_priority;
	logic [1:0]        error_code;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_step_q <= pats_pkg::AGING_STEP_RESET;
		end else if (psel && penable && pwrite && pready && paddr == pats_pkg::REG_AGING_STEP) begin
			aging_step_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr == pats_pkg::REG_AGING_STEP) ? 32'(aging_step_q) : 32'd0;

	pats_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pats_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.func          (s_tuser),
		.task_slot     (s_tdata[3:0]),
		.priority_req  (s_tdata[9:4]),
		.aging_step    (aging_step_q),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.picked_slot   (picked_slot),
		.picked_valid  (picked_valid),
		.slot_priority (slot_priority),
		.error_code    (error_code)
	);

	assign m_tdata = {3'b000, error_code, slot_priority, picked_valid, picked_slot};

endmodule
